>>> hdl/led_skip_region_remapper_unit_assert.svh
// ----------------------------------------------------------------------------
// led skip region remapper assertion macros
// shared property forms for the remapper modules
// ----------------------------------------------------------------------------
`ifndef LED_SKIP_REGION_REMAPPER_UNIT_ASSERT_SVH
`define LED_SKIP_REGION_REMAPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define LSRR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsrr check failed");

// next-cycle implication
`define LSRR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsrr check failed");

`endif

>>> hdl/lsrr_pkg.sv
// ----------------------------------------------------------------------------
// lsrr_pkg
// constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package lsrr_pkg;

    localparam int unsigned MAX_REGIONS = 16;
    localparam int unsigned IDX_W       = $clog2(MAX_REGIONS);
    localparam int unsigned CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int unsigned POS_W       = 16;

    localparam logic [POS_W-1:0] NUM_LEDS  = 16'd1024;
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_REGIONS);

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_MAP   = 2'd2;
    localparam logic [1:0] REQ_CHECK = 2'd3;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    typedef struct packed {
        logic             latch;
        logic             clr_cnt;
        logic             inc_cnt;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             wr_new;
        logic             eval;
        logic             load_out;
    } lsrr_cmd_t;

    typedef struct packed {
        logic [1:0]       req_in;
        logic             add_bad;
        logic             full;
        logic             pos_out;
        logic             cnt_zero;
        logic             start_gt;
        logic [CNT_W-1:0] cnt;
    } lsrr_stat_t;

endpackage

>>> hdl/lsrr_dpath.sv
// ----------------------------------------------------------------------------
// lsrr_dpath
// region table memory, count, walk arithmetic and output registers
// ----------------------------------------------------------------------------
module lsrr_dpath
    import lsrr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lsrr_cmd_t               cmd,
    output lsrr_stat_t              stat,
    input  logic                    cfg_wr_en,
    input  logic signed [POS_W-1:0] cfg_wr_data,
    input  logic [1:0]              req_type,
    input  logic [POS_W-1:0]        region_first,
    input  logic [POS_W-1:0]        region_last,
    input  logic [POS_W-1:0]        led_position,
    output logic [POS_W-1:0]        mapped_position,
    output logic                    position_ok,
    output logic [1:0]              status
);

    logic [2*POS_W-1:0] mem_reg [MAX_REGIONS];
    logic [2*POS_W-1:0] rd_data_reg;

    logic [POS_W-1:0]   base_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         req_reg, req_next;
    logic [POS_W-1:0]   first_reg, first_next;
    logic [POS_W-1:0]   last_reg, last_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   acc_reg, acc_next;
    logic               ok_reg, ok_next;
    logic [1:0]         stat_reg, stat_next;
    logic [POS_W-1:0]   mapped_reg, mapped_next;
    logic               pok_reg, pok_next;
    logic [1:0]         ostat_reg, ostat_next;

    logic [POS_W-1:0]   rd_start, rd_end, rd_len;
    logic               add_bad, full, pos_out;

    assign rd_start = rd_data_reg[2*POS_W-1:POS_W];
    assign rd_end   = rd_data_reg[POS_W-1:0];
    assign rd_len   = rd_end - rd_start + POS_W'(1);

    assign add_bad = (region_first > region_last) || (region_first >= NUM_LEDS)
                     || (region_last >= NUM_LEDS);
    assign full    = (cnt_reg == CNT_FULL);
    assign pos_out = (led_position >= NUM_LEDS);

    always_comb
    begin
        stat.req_in   = req_type;
        stat.add_bad  = add_bad;
        stat.full     = full;
        stat.pos_out  = pos_out;
        stat.cnt_zero = (cnt_reg == '0);
        stat.start_gt = (rd_start > first_reg);
        stat.cnt      = cnt_reg;
    end

    // table storage
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_reg[cmd.wr_addr] <= cmd.wr_new ? {first_reg, last_reg} : rd_data_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem_reg[cmd.rd_addr];
        end
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        req_next    = req_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        ok_next     = ok_reg;
        stat_next   = stat_reg;
        mapped_next = mapped_reg;
        pok_next    = pok_reg;
        ostat_next  = ostat_reg;

        if (cmd.clr_cnt)
        begin
            cnt_next = '0;
        end
        else if (cmd.inc_cnt)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (cmd.latch)
        begin
            req_next   = req_type;
            first_next = region_first;
            last_next  = region_last;
            pos_next   = led_position;
            acc_next   = pos_out ? led_position : led_position + base_reg;
            ok_next    = !pos_out;
            priority if (add_bad)
            begin
                stat_next = STAT_INVALID;
            end
            else if (full)
            begin
                stat_next = STAT_FULL;
            end
            else
            begin
                stat_next = STAT_DONE;
            end
        end
        else if (cmd.eval)
        begin
            priority if (pos_reg > rd_end)
            begin
                acc_next = acc_reg + rd_len;
            end
            else if (pos_reg >= rd_start)
            begin
                acc_next = pos_reg + rd_len;
                ok_next  = 1'b0;
            end
            else
            begin
                acc_next = acc_reg;
            end
        end

        if (cmd.load_out)
        begin
            mapped_next = (req_reg == REQ_MAP) ? acc_reg : '0;
            pok_next    = (req_reg == REQ_CHECK) ? ok_reg : 1'b0;
            ostat_next  = (req_reg == REQ_ADD) ? stat_reg : STAT_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        pos_reg    <= pos_next;
        acc_reg    <= acc_next;
        ok_reg     <= ok_next;
        stat_reg   <= stat_next;
        mapped_reg <= mapped_next;
        pok_reg    <= pok_next;
        ostat_reg  <= ostat_next;
    end

    assign mapped_position = mapped_reg;
    assign position_ok     = pok_reg;
    assign status          = ostat_reg;

`include "led_skip_region_remapper_unit_assert.svh"

    `LSRR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_FULL)
    `LSRR_ASSERT_NOW(a_wr_room, cmd.wr_en, cnt_reg != CNT_FULL)
    `LSRR_ASSERT_NOW(a_eval_req, cmd.eval, req_reg == REQ_MAP || req_reg == REQ_CHECK)

endmodule

>>> hdl/lsrr_ctrl.sv
// ----------------------------------------------------------------------------
// lsrr_ctrl
// request sequencer: table walk, sorted insert and result handshake
// ----------------------------------------------------------------------------
module lsrr_ctrl
    import lsrr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  lsrr_stat_t stat,
    output lsrr_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_WALK    = 3'd1;
    localparam logic [2:0] ST_DRAIN   = 3'd2;
    localparam logic [2:0] ST_ADD_RD  = 3'd3;
    localparam logic [2:0] ST_ADD_CMP = 3'd4;
    localparam logic [2:0] ST_FIN     = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             ovld_reg, ovld_next;
    logic [CNT_W-1:0] idx_m1;
    logic             accept;

    assign idx_m1   = idx_reg - CNT_W'(1);
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        ovld_next    = ovld_reg && out_stall;
        cmd          = '0;
        cmd.rd_addr  = idx_reg[IDX_W-1:0];
        cmd.wr_addr  = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_FIN;
                    unique case (stat.req_in)
                        REQ_CLEAR:
                        begin
                            cmd.clr_cnt = 1'b1;
                        end
                        REQ_ADD:
                        begin
                            if (!stat.add_bad && !stat.full)
                            begin
                                idx_next   = stat.cnt;
                                state_next = ST_ADD_RD;
                            end
                        end
                        REQ_MAP, REQ_CHECK:
                        begin
                            if (!stat.pos_out && !stat.cnt_zero)
                            begin
                                idx_next   = '0;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.rd_en = 1'b1;
                cmd.eval  = (idx_reg != '0);
                idx_next  = idx_reg + CNT_W'(1);
                if (idx_reg == stat.cnt - CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_FIN;
            end
            ST_ADD_RD:
            begin
                if (idx_reg == '0)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_new  = 1'b1;
                    cmd.inc_cnt = 1'b1;
                    state_next  = ST_FIN;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = idx_m1[IDX_W-1:0];
                    state_next  = ST_ADD_CMP;
                end
            end
            ST_ADD_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (stat.start_gt)
                begin
                    idx_next   = idx_m1;
                    state_next = ST_ADD_RD;
                end
                else
                begin
                    cmd.wr_new  = 1'b1;
                    cmd.inc_cnt = 1'b1;
                    state_next  = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!ovld_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    ovld_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ovld_reg  <= ovld_next;
        end
    end

    assign out_valid = ovld_reg;

`include "led_skip_region_remapper_unit_assert.svh"

    `LSRR_ASSERT_NEXT(a_busy_after_accept, accept, in_stall)
    `LSRR_ASSERT_NOW(a_walk_in_table, state_reg == ST_WALK, idx_reg < stat.cnt)
    `LSRR_ASSERT_NEXT(a_out_hold, ovld_reg && out_stall, ovld_reg)

endmodule

>>> hdl/led_skip_region_remapper_unit.sv
// ----------------------------------------------------------------------------
// led_skip_region_remapper_unit
// sequence: clear and a rejected add go straight to the result; add shifts each
//   region that starts after the new one up a slot, then writes the new region
//   map/check walk every region, straight to the result when out of range or empty
// throughput: one request at a time, the next one taken at the edge the result
//   can first be taken; set by the single-port region table walk and shift
// reset: region count and base offset clear, table contents undefined until added
// ----------------------------------------------------------------------------
module led_skip_region_remapper_unit
    import lsrr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              req_type,
    input  logic [POS_W-1:0]        region_first,
    input  logic [POS_W-1:0]        region_last,
    input  logic [POS_W-1:0]        led_position,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [POS_W-1:0]        mapped_position,
    output logic                    position_ok,
    output logic [1:0]              status,
    input  logic                    cfg_wr_en,
    input  logic signed [POS_W-1:0] cfg_wr_data
);

    lsrr_cmd_t  cmd;
    lsrr_stat_t stat;

    lsrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lsrr_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .req_type        (req_type),
        .region_first    (region_first),
        .region_last     (region_last),
        .led_position    (led_position),
        .mapped_position (mapped_position),
        .position_ok     (position_ok),
        .status          (status)
    );

endmodule
